[sv/sq_pkg.sv]
`timescale 1ns / 1ps
// sq_pkg: shared types and constants of the sprite quad vertex transform.
// No dependencies.
package sq_pkg;

  localparam int CordicSteps = 14;
  localparam int FifoDepth   = 4;
  localparam int FifoAw      = $clog2(FifoDepth);
  localparam int QuoBits     = 17;
  localparam int NdcLatency  = QuoBits + 4;
  localparam int BackStages  = 4 + NdcLatency;

  localparam logic signed [16:0] CordicX0 = 17'sd9949;
  localparam logic signed [15:0] AtanSteps [CordicSteps] = '{
    16'sd8192, 16'sd4836, 16'sd2555, 16'sd1297, 16'sd651, 16'sd326, 16'sd163,
    16'sd81, 16'sd41, 16'sd20, 16'sd10, 16'sd5, 16'sd3, 16'sd1
  };

  localparam logic [1:0] RegWindowWidth  = 2'd0;
  localparam logic [1:0] RegWindowHeight = 2'd1;

  localparam logic [14:0] WindowWidthRst  = 15'd1280;
  localparam logic [14:0] WindowHeightRst = 15'd720;

  typedef struct packed {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic [14:0]        width;
    logic [14:0]        height;
    logic signed [15:0] pivot_x;
    logic signed [15:0] pivot_y;
    logic signed [15:0] scale_x;
    logic signed [15:0] scale_y;
  } sprite_t;

  typedef struct packed {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic [14:0]        width;
    logic [14:0]        height;
    logic signed [31:0] pwx;
    logic signed [31:0] pwy;
    logic signed [31:0] kxc;
    logic signed [31:0] kys;
    logic signed [31:0] kxs;
    logic signed [31:0] kyc;
  } job_t;

endpackage

[sv/sq_in_if.sv]
`timescale 1ns / 1ps
// sq_in_if: sprite input channel, valid/ready plus sprite fields.
// No dependencies.
interface sq_in_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] pos_x;
  logic signed [23:0] pos_y;
  logic [14:0]        width;
  logic [14:0]        height;
  logic signed [15:0] pivot_x;
  logic signed [15:0] pivot_y;
  logic signed [15:0] scale_x;
  logic signed [15:0] scale_y;
  logic [15:0]        angle;

  modport source (output valid, pos_x, pos_y, width, height, pivot_x, pivot_y,
                  scale_x, scale_y, angle, input ready);
  modport sink (input valid, pos_x, pos_y, width, height, pivot_x, pivot_y,
                scale_x, scale_y, angle, output ready);
endinterface

[sv/sq_out_if.sv]
`timescale 1ns / 1ps
// sq_out_if: vertex output channel, valid/ready plus corner fields.
// No dependencies.
interface sq_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         corner;
  logic signed [15:0] ndc_x;
  logic signed [15:0] ndc_y;
  logic               tex_u;
  logic               tex_v;
  logic               last;

  modport source (output valid, corner, ndc_x, ndc_y, tex_u, tex_v, last, input ready);
  modport sink (input valid, corner, ndc_x, ndc_y, tex_u, tex_v, last, output ready);
endinterface

[sv/sprite_quad_vertex_transform.sv]
`timescale 1ns / 1ps
// sprite_quad_vertex_transform: top level, window registers, front, queue, back.
// Depends on sq_pkg, sq_in_if, sq_out_if, sq_front, sq_fifo, sq_back.
//
//   port      dir  words
//   sprite_i  in   one sprite
//   vertex_o  out  four corners per sprite, TL BL TR BR
//   cfg_*     in   window width (0) / height (1), write only
//
// Front takes one sprite per cycle unless a finished job waits on a full queue
// (14-stage CORDIC + product stage). Back issues one corner per cycle while the
// output is ready, four corners per sprite through the single output channel.
// Front and back stall separately through a 4-word queue; no clearing pass at reset.
module sprite_quad_vertex_transform (
  input  logic        clk_i,
  input  logic        rst_ni,
  sq_in_if.sink       sprite_i,
  sq_out_if.source    vertex_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [14:0] cfg_data_i
);
  import sq_pkg::*;

  logic [14:0] win_w_q, win_h_q;
  logic        f_valid, f_full, q_valid, q_pop;
  job_t        f_job, q_job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_w_q <= WindowWidthRst;
      win_h_q <= WindowHeightRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegWindowWidth:  win_w_q <= cfg_data_i;
        RegWindowHeight: win_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  sq_front u_front (
    .clk_i, .rst_ni, .sprite(sprite_i), .full_i(f_full),
    .job_valid_o(f_valid), .job_o(f_job)
  );

  sq_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(f_valid && !f_full), .data_i(f_job), .full_o(f_full),
    .pop_i(q_pop), .valid_o(q_valid), .data_o(q_job)
  );

  sq_back u_back (
    .clk_i, .rst_ni, .job_valid_i(q_valid), .job_i(q_job), .job_pop_o(q_pop),
    .win_w_i(win_w_q), .win_h_i(win_h_q), .vertex(vertex_o)
  );

endmodule

[sv/sq_front.sv]
`timescale 1ns / 1ps
// sq_front: accepts sprites, pipelined CORDIC sin/cos, per-sprite coefficient products.
// Depends on sq_pkg, sq_in_if.
module sq_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  sq_in_if.sink         sprite,
  input  logic          full_i,
  output logic          job_valid_o,
  output sq_pkg::job_t  job_o
);
  import sq_pkg::*;

  logic                     en;
  logic [CordicSteps-1:0]   vld_q;
  sprite_t                  spr_q  [CordicSteps];
  logic signed [16:0]       x_q    [CordicSteps];
  logic signed [16:0]       y_q    [CordicSteps];
  logic signed [15:0]       z_q    [CordicSteps];
  logic [1:0]               quad_q [CordicSteps];
  sprite_t                  spr_in;
  logic                     vldp_q;
  job_t                     job_q;

  assign en           = !(vldp_q && full_i);
  assign sprite.ready = en;

  assign spr_in = '{pos_x: sprite.pos_x, pos_y: sprite.pos_y, width: sprite.width,
                    height: sprite.height, pivot_x: sprite.pivot_x,
                    pivot_y: sprite.pivot_y, scale_x: sprite.scale_x,
                    scale_y: sprite.scale_y};

  for (genvar g = 0; g < CordicSteps; g++) begin : g_cordic
    logic signed [16:0] xin, yin;
    logic signed [15:0] zin;
    sprite_t            sin;
    logic [1:0]         qin;
    if (g == 0) begin : g_first
      assign xin = CordicX0;
      assign yin = '0;
      assign zin = $signed({2'b00, sprite.angle[13:0]});
      assign sin = spr_in;
      assign qin = sprite.angle[15:14];
    end else begin : g_next
      assign xin = x_q[g-1];
      assign yin = y_q[g-1];
      assign zin = z_q[g-1];
      assign sin = spr_q[g-1];
      assign qin = quad_q[g-1];
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (zin >= 0) begin
          x_q[g] <= xin - (yin >>> g);
          y_q[g] <= yin + (xin >>> g);
          z_q[g] <= zin - AtanSteps[g];
        end else begin
          x_q[g] <= xin + (yin >>> g);
          y_q[g] <= yin - (xin >>> g);
          z_q[g] <= zin + AtanSteps[g];
        end
        spr_q[g]  <= sin;
        quad_q[g] <= qin;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      vldp_q <= 1'b0;
    end else if (en) begin
      vld_q  <= {vld_q[CordicSteps-2:0], sprite.valid};
      vldp_q <= vld_q[CordicSteps-1];
    end
  end

  logic signed [17:0] cx, cy, cs, sn;
  logic signed [33:0] p_xc, p_ys, p_xs, p_yc;
  logic signed [31:0] p_wx, p_wy;
  sprite_t            sl;

  assign sl = spr_q[CordicSteps-1];
  assign cx = 18'(x_q[CordicSteps-1]);
  assign cy = 18'(y_q[CordicSteps-1]);

  always_comb begin
    unique case (quad_q[CordicSteps-1])
      2'd0:    begin cs = cx;  sn = cy;  end
      2'd1:    begin cs = -cy; sn = cx;  end
      2'd2:    begin cs = -cx; sn = -cy; end
      default: begin cs = cy;  sn = -cx; end
    endcase
  end

  assign p_xc = sl.scale_x * cs;
  assign p_ys = sl.scale_y * sn;
  assign p_xs = sl.scale_x * sn;
  assign p_yc = sl.scale_y * cs;
  assign p_wx = sl.pivot_x * $signed({1'b0, sl.width});
  assign p_wy = sl.pivot_y * $signed({1'b0, sl.height});

  always_ff @(posedge clk_i) begin
    if (en) begin
      job_q.pos_x  <= sl.pos_x;
      job_q.pos_y  <= sl.pos_y;
      job_q.width  <= sl.width;
      job_q.height <= sl.height;
      job_q.pwx    <= p_wx;
      job_q.pwy    <= p_wy;
      job_q.kxc    <= p_xc[31:0];
      job_q.kys    <= p_ys[31:0];
      job_q.kxs    <= p_xs[31:0];
      job_q.kyc    <= p_yc[31:0];
    end
  end

  assign job_valid_o = vldp_q;
  assign job_o       = job_q;

endmodule

[sv/sq_fifo.sv]
`timescale 1ns / 1ps
// sq_fifo: short word queue between front and back.
// Depends on sq_pkg.
module sq_fifo (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  sq_pkg::job_t data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         valid_o,
  output sq_pkg::job_t data_o
);
  import sq_pkg::*;

  job_t              mem_q [FifoDepth];
  logic [FifoAw-1:0] wr_q, rd_q;
  logic [FifoAw:0]   cnt_q;

  assign full_o  = (cnt_q == (FifoAw+1)'(FifoDepth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (FifoAw+1)'(push_i) - (FifoAw+1)'(pop_i);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("pop from empty queue");

endmodule

[sv/sq_ndc.sv]
`timescale 1ns / 1ps
// sq_ndc: one axis: pixel rounding, pipelined rounded division by window size,
// offset and saturation to Q4.12. Depends on sq_pkg.
module sq_ndc (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic               flip_i,
  input  logic signed [63:0] v_i,
  input  logic [14:0]        div_i,
  output logic signed [15:0] ndc_o
);
  import sq_pkg::*;

  logic [63:0] a_m_q;
  logic        a_neg_q;
  logic [14:0] a_d_q;
  logic [30:0] b_n_q;
  logic        b_neg_q;
  logic [14:0] b_d_q;
  logic [29:0] b_q;
  logic [44:0] c_rem;

  logic [44:0]         rem_q [QuoBits+1];
  logic [QuoBits-1:0]  quo_q [QuoBits+1];
  logic [15:0]         dv_q  [QuoBits+1];
  logic                ovf_q [QuoBits+1];
  logic                tn_q  [QuoBits+1];
  logic signed [15:0]  ndc_q;

  assign b_q   = a_m_q[63:34];
  assign c_rem = {1'b0, b_n_q, 13'b0} + {30'b0, b_d_q};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_neg_q <= v_i[63];
      a_m_q   <= (v_i[63] ? ~v_i : v_i) +
                 (v_i[63] ? 64'h0000_0002_0000_0001 : 64'h0000_0002_0000_0000);
      a_d_q   <= div_i;
      b_neg_q <= a_neg_q || (b_q == '0);
      if (a_neg_q) b_n_q <= {b_q, 1'b1};
      else if (b_q == '0) b_n_q <= 31'd1;
      else b_n_q <= {b_q, 1'b0} - 31'd1;
      b_d_q     <= a_d_q;
      rem_q[0]  <= c_rem;
      quo_q[0]  <= '0;
      dv_q[0]   <= {b_d_q, 1'b0};
      ovf_q[0]  <= c_rem >= {12'b0, b_d_q, 1'b0, 17'b0};
      tn_q[0]   <= b_neg_q;
    end
  end

  for (genvar j = 0; j < QuoBits; j++) begin : g_div
    localparam int Sh = QuoBits - 1 - j;
    logic [44:0] cmp;
    logic        ge;
    assign cmp = {29'b0, dv_q[j]} << Sh;
    assign ge  = rem_q[j] >= cmp;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j+1] <= ge ? rem_q[j] - cmp : rem_q[j];
        quo_q[j+1] <= {quo_q[j][QuoBits-2:0], ge};
        dv_q[j+1]  <= dv_q[j];
        ovf_q[j+1] <= ovf_q[j];
        tn_q[j+1]  <= tn_q[j];
      end
    end
  end

  logic signed [19:0] qs, val;
  assign qs  = tn_q[QuoBits] ? -$signed({3'b0, quo_q[QuoBits]})
                             : $signed({3'b0, quo_q[QuoBits]});
  assign val = flip_i ? 20'sd4096 - qs : qs - 20'sd4096;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (ovf_q[QuoBits]) ndc_q <= (tn_q[QuoBits] ^ flip_i) ? -16'sd32768 : 16'sd32767;
      else if (val > 20'sd32767) ndc_q <= 16'sd32767;
      else if (val < -20'sd32768) ndc_q <= -16'sd32768;
      else ndc_q <= val[15:0];
    end
  end

  assign ndc_o = ndc_q;

endmodule

[sv/sq_back.sv]
`timescale 1ns / 1ps
// sq_back: issues four corners per queued sprite, rotation products, position add,
// two sq_ndc axis pipes, output word register. Depends on sq_pkg, sq_out_if, sq_ndc.
module sq_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  input  sq_pkg::job_t  job_i,
  output logic          job_pop_o,
  input  logic [14:0]   win_w_i,
  input  logic [14:0]   win_h_i,
  sq_out_if.source      vertex
);
  import sq_pkg::*;

  logic                  en, issue;
  logic [1:0]            k_q;
  logic [BackStages-1:0] vld_q;
  logic [1:0]            cor_q [BackStages];
  logic signed [31:0]    px_q, py_q, kxc_q, kys_q, kxs_q, kyc_q;
  logic signed [23:0]    posx_q [3];
  logic signed [23:0]    posy_q [3];
  logic signed [63:0]    ma_q, mb_q, mc_q, md_q, rx_q, ry_q, vx_q, vy_q;
  logic signed [31:0]    px_d, py_d;
  logic [14:0]           dw, dh;
  logic signed [15:0]    ndc_x, ndc_y;

  assign en        = !(vld_q[BackStages-1] && !vertex.ready);
  assign issue     = en && job_valid_i;
  assign job_pop_o = issue && (k_q == 2'd3);

  assign px_d = (k_q[1] ? $signed({5'b0, job_i.width, 12'b0}) : 32'sd0) - job_i.pwx;
  assign py_d = (k_q[0] ? $signed({5'b0, job_i.height, 12'b0}) : 32'sd0) - job_i.pwy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q   <= '0;
      vld_q <= '0;
    end else if (en) begin
      if (issue) k_q <= k_q + 2'd1;
      vld_q <= {vld_q[BackStages-2:0], job_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cor_q[0]  <= k_q;
      px_q      <= px_d;
      py_q      <= py_d;
      kxc_q     <= job_i.kxc;
      kys_q     <= job_i.kys;
      kxs_q     <= job_i.kxs;
      kyc_q     <= job_i.kyc;
      posx_q[0] <= job_i.pos_x;
      posy_q[0] <= job_i.pos_y;
      ma_q      <= px_q * kxc_q;
      mb_q      <= py_q * kys_q;
      mc_q      <= px_q * kxs_q;
      md_q      <= py_q * kyc_q;
      posx_q[1] <= posx_q[0];
      posy_q[1] <= posy_q[0];
      rx_q      <= ma_q + mb_q;
      ry_q      <= md_q - mc_q;
      posx_q[2] <= posx_q[1];
      posy_q[2] <= posy_q[1];
      vx_q      <= rx_q + $signed({{14{posx_q[2][23]}}, posx_q[2], 26'b0});
      vy_q      <= ry_q + $signed({{14{posy_q[2][23]}}, posy_q[2], 26'b0});
    end
  end

  for (genvar s = 1; s < BackStages; s++) begin : g_cor
    always_ff @(posedge clk_i) begin
      if (en) cor_q[s] <= cor_q[s-1];
    end
  end

  assign dw = (win_w_i == '0) ? 15'd1 : win_w_i;
  assign dh = (win_h_i == '0) ? 15'd1 : win_h_i;

  sq_ndc u_ndc_x (.clk_i, .en_i(en), .flip_i(1'b0), .v_i(vx_q), .div_i(dw), .ndc_o(ndc_x));
  sq_ndc u_ndc_y (.clk_i, .en_i(en), .flip_i(1'b1), .v_i(vy_q), .div_i(dh), .ndc_o(ndc_y));

  assign vertex.valid  = vld_q[BackStages-1];
  assign vertex.corner = cor_q[BackStages-1];
  assign vertex.ndc_x  = ndc_x;
  assign vertex.ndc_y  = ndc_y;
  assign vertex.tex_u  = cor_q[BackStages-1][1];
  assign vertex.tex_v  = cor_q[BackStages-1][0];
  assign vertex.last   = (cor_q[BackStages-1] == 2'd3);

  a_pop_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop_o |-> (k_q == 2'd3 && job_valid_i)) else $error("sprite popped early");

endmodule
